// ===== design/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and constants of the pose frame deframer
// Register map, decoded result layout and sign-magnitude conversion.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int FRAME_BYTES_DEF = 15;
    localparam int BYTE_W          = 8;
    localparam int VALUE_W         = 24;
    localparam int STAMP_W         = 16;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SYNC     = 3'd0;
    localparam logic [2:0] REG_POS_TYPE = 3'd1;
    localparam logic [2:0] REG_ATT_TYPE = 3'd2;
    localparam logic [2:0] REG_END_HIGH = 3'd3;
    localparam logic [2:0] REG_END_LOW  = 3'd4;

    // result kinds
    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_ATTITUDE = 1'b1;

    // fixed frame offsets, oldest byte first
    localparam int OFS_TYPE    = 1;
    localparam int OFS_STAMP   = 2;
    localparam int OFS_VALUE_A = 4;
    localparam int OFS_VALUE_B = 7;
    localparam int OFS_VALUE_C = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_byte;
        logic [BYTE_W-1:0] position_type_byte;
        logic [BYTE_W-1:0] attitude_type_byte;
        logic [BYTE_W-1:0] end_high_byte;
        logic [BYTE_W-1:0] end_low_byte;
    } cfg_t;

    typedef struct packed {
        logic hit_pos;
        logic hit_att;
    } match_t;

    typedef struct packed {
        logic                       frame_kind;
        logic signed [VALUE_W-1:0]  value_a;
        logic signed [VALUE_W-1:0]  value_b;
        logic signed [VALUE_W-1:0]  value_c;
        logic [STAMP_W-1:0]         stamp;
        logic                       set_complete;
    } result_t;

    // sign-magnitude (bit 23 is the sign) to two's complement
    function automatic logic signed [VALUE_W-1:0] sm_to_tc(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        mag = {1'b0, raw[VALUE_W-2:0]};
        if (raw[VALUE_W-1])
        begin
            return VALUE_W'(0) - mag;
        end
        return raw;
    endfunction

endpackage

// ===== design/pose_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// pose_frame_deframer_core: serial pose frame deframer
// Slides received bytes through a frame-sized window and reports position
// and attitude frames as raw scaled integers.
// ----------------------------------------------------------------------------
// Path: a byte lands in the input register at its transfer edge; window compare
//   and decode fill the result register once that byte is processed, which
//   waits while a stalled result is held. Throughput: one byte per cycle,
//   save while a result is stalled; set by the single window update per cycle.
// Reset: rst_n clears both valid flags, the fill count, the pairing flag and
//   the configuration registers; the window bytes themselves are not cleared.
module pose_frame_deframer_core #(
    parameter int FRAME_BYTES = pfd_pkg::FRAME_BYTES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfd_pkg::ADDR_W-1:0]          paddr,
    input  logic [pfd_pkg::DATA_W-1:0]          pwdata,
    output logic [pfd_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // byte input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pfd_pkg::BYTE_W-1:0]          rx_byte,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                frame_kind,
    output logic signed [pfd_pkg::VALUE_W-1:0]  value_a,
    output logic signed [pfd_pkg::VALUE_W-1:0]  value_b,
    output logic signed [pfd_pkg::VALUE_W-1:0]  value_c,
    output logic [pfd_pkg::STAMP_W-1:0]         stamp,
    output logic                                set_complete
);

    pfd_pkg::cfg_t     cfg;
    pfd_pkg::match_t   match;
    pfd_pkg::result_t  result;
    pfd_pkg::result_t  result_reg;

    logic [FRAME_BYTES-1:0][pfd_pkg::BYTE_W-1:0] win_view;
    logic win_full;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [pfd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        position_seen_reg;
    logic                        position_seen_next;

    logic in_accept;
    logic advance;
    logic fire;
    logic hit;

    // ------------------------------------------------------------------
    // Handshake: the held byte moves on whenever the result register can
    // take a new result, so a stalled result never blocks more than one
    // byte behind it.
    // ------------------------------------------------------------------
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign hit       = match.hit_pos || match.hit_att;

    pfd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // window shifts on every processed byte; a recognised frame empties it
    pfd_window #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte_reg),
        .shift_en (fire),
        .flush    (fire && hit),
        .view     (win_view),
        .full     (win_full)
    );

    pfd_frame_match #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_match
    (
        .view          (win_view),
        .full          (win_full),
        .cfg           (cfg),
        .position_seen (position_seen_reg),
        .match         (match),
        .result        (result)
    );

    always_comb
    begin
        // input register: load on a transfer, drop once processed
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        // result register: hold while stalled, advance on a new frame
        out_valid_next = out_valid_reg && out_stall;
        if (fire && hit)
        begin
            out_valid_next = 1'b1;
        end

        // pairing flag: position arms it, a completed attitude clears it
        position_seen_next = position_seen_reg;
        if (fire && match.hit_pos)
        begin
            position_seen_next = 1'b1;
        end
        else if (fire && match.hit_att)
        begin
            position_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            position_seen_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            position_seen_reg <= position_seen_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (fire && hit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_kind   = result_reg.frame_kind;
    assign value_a      = result_reg.value_a;
    assign value_b      = result_reg.value_b;
    assign value_c      = result_reg.value_c;
    assign stamp        = result_reg.stamp;
    assign set_complete = result_reg.set_complete;

`ifndef SYNTHESIS
    // a recognised frame leaves an empty window behind it
    a_flush_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && hit) |=> !win_full)
        else $error("window still full after a frame");

    // a completed attitude frame disarms the pairing flag
    a_att_disarms : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && match.hit_att) |=> !position_seen_reg)
        else $error("pairing flag still set after attitude frame");

    // position results carry no stamp and no completion mark
    a_pos_fields : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (frame_kind == pfd_pkg::KIND_POSITION))
            |-> (stamp == '0) && !set_complete)
        else $error("position result with stamp or completion");
`endif

endmodule

// ===== design/pfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pfd_cfg_regs: configuration register file
// APB-style write and read of the five frame marker bytes.
// ----------------------------------------------------------------------------
module pfd_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pfd_pkg::DATA_W-1:0]   pwdata,
    output logic [pfd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output pfd_pkg::cfg_t                cfg
);

    pfd_pkg::cfg_t    cfg_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;
    logic [pfd_pkg::BYTE_W-1:0] wbyte;
    logic [pfd_pkg::BYTE_W-1:0] rbyte;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pfd_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wbyte   = pwdata[pfd_pkg::BYTE_W-1:0];
    assign cfg     = cfg_reg;

    always_comb
    begin
        case (reg_idx)
            pfd_pkg::REG_SYNC:     rbyte = cfg_reg.sync_byte;
            pfd_pkg::REG_POS_TYPE: rbyte = cfg_reg.position_type_byte;
            pfd_pkg::REG_ATT_TYPE: rbyte = cfg_reg.attitude_type_byte;
            pfd_pkg::REG_END_HIGH: rbyte = cfg_reg.end_high_byte;
            pfd_pkg::REG_END_LOW:  rbyte = cfg_reg.end_low_byte;
            default:               rbyte = '0;
        endcase
        prdata = pfd_pkg::DATA_W'(rbyte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pfd_pkg::REG_SYNC:     cfg_reg.sync_byte          <= wbyte;
                pfd_pkg::REG_POS_TYPE: cfg_reg.position_type_byte <= wbyte;
                pfd_pkg::REG_ATT_TYPE: cfg_reg.attitude_type_byte <= wbyte;
                pfd_pkg::REG_END_HIGH: cfg_reg.end_high_byte      <= wbyte;
                pfd_pkg::REG_END_LOW:  cfg_reg.end_low_byte       <= wbyte;
                default:               ; // unmapped: drop the write
            endcase
        end
    end

endmodule

// ===== design/pfd_window.sv =====
// ----------------------------------------------------------------------------
// pfd_window: byte window shift line with fill count
// Presents the window as it stands once the pending byte is shifted in.
// ----------------------------------------------------------------------------
module pfd_window #(
    parameter int FRAME_BYTES = pfd_pkg::FRAME_BYTES_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [pfd_pkg::BYTE_W-1:0]                  in_byte,
    input  logic                                        shift_en,
    input  logic                                        flush,
    output logic [FRAME_BYTES-1:0][pfd_pkg::BYTE_W-1:0] view,
    output logic                                        full
);

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);

    logic [FRAME_BYTES-1:0][pfd_pkg::BYTE_W-1:0] window_reg;
    logic [FILL_W-1:0]                            fill_reg;
    logic [FILL_W-1:0]                            fill_view;
    logic [FILL_W-1:0]                            fill_next;

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            view[i] = window_reg[i + 1];
        end
        view[FRAME_BYTES-1] = in_byte;
    end

    // saturate at a full window
    assign fill_view = (fill_reg == FILL_W'(FRAME_BYTES)) ? fill_reg : fill_reg + 1'b1;
    assign full      = (fill_view == FILL_W'(FRAME_BYTES));

    always_comb
    begin
        fill_next = fill_reg;
        if (flush)
        begin
            fill_next = '0;
        end
        else if (shift_en)
        begin
            fill_next = fill_view;
        end
    end

    // bytes behind an empty fill count are never compared: no reset needed
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            window_reg <= view;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== design/pfd_frame_match.sv =====
// ----------------------------------------------------------------------------
// pfd_frame_match: frame recognition and field decode
// Compares marker bytes at fixed offsets and unpacks the three values.
// ----------------------------------------------------------------------------
module pfd_frame_match #(
    parameter int FRAME_BYTES = pfd_pkg::FRAME_BYTES_DEF
)
(
    input  logic [FRAME_BYTES-1:0][pfd_pkg::BYTE_W-1:0] view,
    input  logic                                        full,
    input  pfd_pkg::cfg_t                               cfg,
    input  logic                                        position_seen,
    output pfd_pkg::match_t                             match,
    output pfd_pkg::result_t                            result
);

    logic framed;
    logic type_pos;
    logic type_att;

    assign framed = full
                 && (view[0]               == cfg.sync_byte)
                 && (view[FRAME_BYTES - 2] == cfg.end_high_byte)
                 && (view[FRAME_BYTES - 1] == cfg.end_low_byte);

    assign type_pos = (view[pfd_pkg::OFS_TYPE] == cfg.position_type_byte);
    assign type_att = (view[pfd_pkg::OFS_TYPE] == cfg.attitude_type_byte);

    // position wins when both type bytes agree
    assign match.hit_pos = framed && type_pos;
    assign match.hit_att = framed && !type_pos && type_att && position_seen;

    always_comb
    begin
        result.frame_kind = match.hit_att ? pfd_pkg::KIND_ATTITUDE : pfd_pkg::KIND_POSITION;
        result.value_a = pfd_pkg::sm_to_tc({view[pfd_pkg::OFS_VALUE_A],
                                            view[pfd_pkg::OFS_VALUE_A + 1],
                                            view[pfd_pkg::OFS_VALUE_A + 2]});
        result.value_b = pfd_pkg::sm_to_tc({view[pfd_pkg::OFS_VALUE_B],
                                            view[pfd_pkg::OFS_VALUE_B + 1],
                                            view[pfd_pkg::OFS_VALUE_B + 2]});
        result.value_c = pfd_pkg::sm_to_tc({view[pfd_pkg::OFS_VALUE_C],
                                            view[pfd_pkg::OFS_VALUE_C + 1],
                                            view[pfd_pkg::OFS_VALUE_C + 2]});
        result.stamp        = '0;
        result.set_complete = 1'b0;
        if (match.hit_att)
        begin
            result.stamp        = {view[pfd_pkg::OFS_STAMP], view[pfd_pkg::OFS_STAMP + 1]};
            result.set_complete = 1'b1;
        end
    end

endmodule
